// ===== rtl/assert_macros.svh =====
// assertion helpers used by the top-level rtl file
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PTDP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define PTDP_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/ptdp_pkg.sv =====
// types and codes for the point table dedup/prune unit
// no dependencies; used by the interfaces, ptdp_check and the top level
package ptdp_pkg;

	localparam int unsigned CNT_W = 7;

	typedef logic signed [31:0] coord_t;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_PRUNE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_FIN
	} st_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} entry_t;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} rect_t;

	typedef struct packed {
		op_t    op;
		coord_t pos_x;
		coord_t pos_y;
		coord_t rect_left;
		coord_t rect_top;
		coord_t rect_right;
		coord_t rect_bottom;
	} in_item_t;

	typedef struct packed {
		logic             duplicate;
		logic             stored;
		logic [CNT_W-1:0] removed_count;
		logic [CNT_W-1:0] entry_count;
	} out_item_t;

	// per-entry compare outcome
	typedef struct packed {
		logic hit;
		logic keep;
	} chk_t;

endpackage

// ===== rtl/ptdp_if.sv =====
// valid/ready channels for command and result transactions
// depends on ptdp_pkg
interface ptdp_in_if;
	logic               valid;
	logic               ready;
	ptdp_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ptdp_out_if;
	logic                valid;
	logic                ready;
	ptdp_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ptdp_check.sv =====
// per-entry compare: equality against the offered point, rectangle test
// depends on ptdp_pkg
module ptdp_check (
	input  ptdp_pkg::entry_t point,
	input  ptdp_pkg::rect_t  rect,
	input  ptdp_pkg::entry_t entry,
	output ptdp_pkg::chk_t   chk
);

	always_comb begin
		chk.hit  = (entry.x == point.x) && (entry.y == point.y);
		// edges inclusive, an inverted rectangle keeps nothing
		chk.keep = (entry.x >= rect.left) && (entry.x <= rect.right) &&
			(entry.y >= rect.top) && (entry.y <= rect.bottom);
	end

endmodule

// ===== rtl/point_table_dedup_prune_unit.sv =====
// top level of the point table: entry memory, scan sequencer, result register
// depends on ptdp_pkg, ptdp_if, ptdp_check and assert_macros.svh
//
// channel | dir | payload
// cmd     | in  | op, pos_x, pos_y, rect_left, rect_top, rect_right, rect_bottom
// res     | out | duplicate, stored, removed_count, entry_count
//
// each stored point is scanned in a memory read step (ST_RD) and a compare step
// (ST_CHK), the compaction write going out in the compare step; an add stops early
// at the first equal point, and an empty table goes straight to ST_FIN to load
// the result. the next transaction can be accepted in the cycle after the load.
// reset clears count and scan state, not the entries; entries are valid below the count.
// a new transaction is accepted while a result still waits on res; the
// sequencer holds in its final step until the result register is free.
`include "assert_macros.svh"

module point_table_dedup_prune_unit #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	ptdp_in_if.sink    cmd,
	ptdp_out_if.source res
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	ptdp_pkg::st_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] wr_q;
	logic [CW-1:0] rm_q;
	logic          dup_q;
	logic          res_valid_q;

	ptdp_pkg::op_t       op_q;
	ptdp_pkg::entry_t    pt_q;
	ptdp_pkg::rect_t     rect_q;
	ptdp_pkg::out_item_t res_q;
	ptdp_pkg::entry_t    rd_q;

	ptdp_pkg::entry_t mem [TABLE_DEPTH];

	ptdp_pkg::chk_t      chk;
	ptdp_pkg::out_item_t res_d;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	ptdp_pkg::entry_t    mem_wd;
	logic                take;
	logic                last;
	logic                out_free;
	logic                load_res;
	logic                store_ok;
	logic [CW-1:0]       idx_nx;

	assign take     = cmd.valid && cmd.ready;
	assign idx_nx   = CW'(idx_q) + CW'(1);
	assign last     = (idx_nx == count_q);
	assign out_free = !res_valid_q || res.ready;
	assign store_ok = (op_q == ptdp_pkg::OP_ADD) && !dup_q && (count_q < CW'(TABLE_DEPTH));

	ptdp_check u_check (
		.point (pt_q),
		.rect  (rect_q),
		.entry (rd_q),
		.chk   (chk)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptdp_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_d = (count_q == '0) ? ptdp_pkg::ST_FIN : ptdp_pkg::ST_RD;
				end
			end
			ptdp_pkg::ST_RD: begin
				state_d = ptdp_pkg::ST_CHK;
			end
			ptdp_pkg::ST_CHK: begin
				if (((op_q == ptdp_pkg::OP_ADD) && chk.hit) || last) begin
					state_d = ptdp_pkg::ST_FIN;
				end else begin
					state_d = ptdp_pkg::ST_RD;
				end
			end
			ptdp_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = ptdp_pkg::ST_IDLE;
				end
			end
			default: state_d = ptdp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready = (state_q == ptdp_pkg::ST_IDLE);
		mem_we    = 1'b0;
		mem_wa    = wr_q[AW-1:0];
		mem_wd    = rd_q;
		load_res  = 1'b0;
		unique case (state_q)
			ptdp_pkg::ST_CHK: begin
				// compaction writes behind the read pointer, so no forwarding
				mem_we = (op_q == ptdp_pkg::OP_PRUNE) && chk.keep;
			end
			ptdp_pkg::ST_FIN: begin
				load_res = out_free;
				mem_we   = out_free && store_ok;
				mem_wa   = count_q[AW-1:0];
				mem_wd   = pt_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		res_d.duplicate = (op_q == ptdp_pkg::OP_ADD) && dup_q;
		res_d.stored    = store_ok;
		if (op_q == ptdp_pkg::OP_PRUNE) begin
			res_d.removed_count = ptdp_pkg::CNT_W'(rm_q);
			res_d.entry_count   = ptdp_pkg::CNT_W'(wr_q);
		end else begin
			res_d.removed_count = '0;
			res_d.entry_count   = ptdp_pkg::CNT_W'(count_q + CW'(store_ok));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptdp_pkg::ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			wr_q        <= '0;
			rm_q        <= '0;
			dup_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				idx_q <= '0;
				wr_q  <= '0;
				rm_q  <= '0;
				dup_q <= 1'b0;
			end
			if (state_q == ptdp_pkg::ST_CHK) begin
				idx_q <= idx_nx[AW-1:0];
				if (op_q == ptdp_pkg::OP_ADD) begin
					if (chk.hit) begin
						dup_q <= 1'b1;
					end
				end else if (chk.keep) begin
					wr_q <= wr_q + CW'(1);
				end else begin
					rm_q <= rm_q + CW'(1);
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
				if (op_q == ptdp_pkg::OP_PRUNE) begin
					count_q <= wr_q;
				end else if (store_ok) begin
					count_q <= count_q + CW'(1);
				end
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q        <= cmd.data.op;
			pt_q.x      <= cmd.data.pos_x;
			pt_q.y      <= cmd.data.pos_y;
			rect_q.left   <= cmd.data.rect_left;
			rect_q.top    <= cmd.data.rect_top;
			rect_q.right  <= cmd.data.rect_right;
			rect_q.bottom <= cmd.data.rect_bottom;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[idx_q];
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	`PTDP_NEVER(a_count_range, clk, arst_n, count_q > CW'(TABLE_DEPTH), "count beyond depth")

	`PTDP_ASSERT(a_prune_balance, clk, arst_n,
		(state_q == ptdp_pkg::ST_FIN && op_q == ptdp_pkg::OP_PRUNE) |->
		((CW+1)'(wr_q) + (CW+1)'(rm_q) == (CW+1)'(count_q)), "kept plus removed differs from count")

	`PTDP_ASSERT(a_compact_behind, clk, arst_n,
		(state_q == ptdp_pkg::ST_CHK) |-> (wr_q <= CW'(idx_q)), "compaction write ahead of read")

	`PTDP_ASSERT(a_result_held, clk, arst_n,
		(res_valid_q && !res.ready) |=> (res_valid_q && $stable(res_q)), "pending result lost")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for point_table_dedup_prune_unit: adds and prunes through the cmd channel,
// results checked against a table model kept in the bench
// depends on ptdp_pkg, ptdp_if and the rtl top level
module tb;

	localparam int DEPTH = 64;
	localparam int IDLE_PCT = 27;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int ITEM_TARGET = 1100;
	localparam ptdp_pkg::coord_t C_MIN = 32'sh8000_0000;
	localparam ptdp_pkg::coord_t C_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;

	ptdp_in_if cmd_ch ();
	ptdp_out_if res_ch ();

	point_table_dedup_prune_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// bench copy of the point table
	ptdp_pkg::coord_t kept_x [DEPTH];
	ptdp_pkg::coord_t kept_y [DEPTH];
	int               kept_count;

	ptdp_pkg::in_item_t  pending_cmds [$];
	ptdp_pkg::out_item_t awaited_outcomes [$];
	int        items_queued;
	int        n_accepted;
	int        n_checked;
	int        n_errors;
	bit        cmd_taken;
	bit        calm;
	bit        hold_res;
	int        n_adds, n_dups, n_refused, n_prunes, n_removed;

	always #1 clk = ~clk;

	// updates the table model with one transaction and returns the expected result
	function automatic ptdp_pkg::out_item_t apply_to_table(ptdp_pkg::in_item_t item);
		ptdp_pkg::out_item_t r;
		int w;
		int removed;
		logic hit;
		r = '0;
		w = 0;
		removed = 0;
		hit = 1'b0;
		if (item.op == ptdp_pkg::OP_ADD) begin
			for (int i = 0; i < kept_count; i++) begin
				if (kept_x[i] == item.pos_x && kept_y[i] == item.pos_y)
					hit = 1'b1;
			end
			r.duplicate = hit;
			if (!hit && kept_count < DEPTH) begin
				kept_x[kept_count] = item.pos_x;
				kept_y[kept_count] = item.pos_y;
				kept_count++;
				r.stored = 1'b1;
			end
		end else begin
			for (int i = 0; i < kept_count; i++) begin
				if ($signed(kept_x[i]) >= $signed(item.rect_left)
						&& $signed(kept_x[i]) <= $signed(item.rect_right)
						&& $signed(kept_y[i]) >= $signed(item.rect_top)
						&& $signed(kept_y[i]) <= $signed(item.rect_bottom)) begin
					kept_x[w] = kept_x[i];
					kept_y[w] = kept_y[i];
					w++;
				end else begin
					removed++;
				end
			end
			kept_count = w;
			r.removed_count = removed[ptdp_pkg::CNT_W-1:0];
		end
		r.entry_count = kept_count[ptdp_pkg::CNT_W-1:0];
		return r;
	endfunction

	function automatic ptdp_pkg::coord_t grid_coord();
		return ptdp_pkg::coord_t'($urandom_range(16)) - 8;
	endfunction

	function automatic ptdp_pkg::coord_t any_coord();
		case ($urandom_range(9))
			0: return C_MIN;
			1: return C_MAX;
			2, 3: return grid_coord();
			default: return ptdp_pkg::coord_t'($urandom);
		endcase
	endfunction

	// unused fields of each transaction carry random bits
	task automatic queue_add(ptdp_pkg::coord_t x, ptdp_pkg::coord_t y);
		ptdp_pkg::in_item_t it;
		it = ptdp_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		it.op = ptdp_pkg::OP_ADD;
		it.pos_x = x;
		it.pos_y = y;
		pending_cmds.push_back(it);
		items_queued++;
	endtask

	task automatic queue_prune(ptdp_pkg::coord_t l, ptdp_pkg::coord_t t,
			ptdp_pkg::coord_t r, ptdp_pkg::coord_t b);
		ptdp_pkg::in_item_t it;
		it = ptdp_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		it.op = ptdp_pkg::OP_PRUNE;
		it.rect_left = l;
		it.rect_top = t;
		it.rect_right = r;
		it.rect_bottom = b;
		pending_cmds.push_back(it);
		items_queued++;
	endtask

	task automatic queue_random_prune();
		ptdp_pkg::coord_t l, t;
		l = grid_coord();
		t = grid_coord();
		case ($urandom_range(9))
			0: queue_prune(C_MIN, C_MIN, C_MAX, C_MAX);
			1: queue_prune(l, t, l - ptdp_pkg::coord_t'($urandom_range(4, 1)), t + 8);
			2: queue_prune(ptdp_pkg::coord_t'(0), C_MIN, C_MAX, C_MAX);
			3: queue_prune(any_coord(), any_coord(), any_coord(), any_coord());
			default: queue_prune(l - 4, t - 4, l + ptdp_pkg::coord_t'($urandom_range(12)),
				t + ptdp_pkg::coord_t'($urandom_range(12)));
		endcase
	endtask

	task automatic queue_fill_run();
		repeat ($urandom_range(72, 40))
			queue_add(ptdp_pkg::coord_t'($urandom), ptdp_pkg::coord_t'($urandom));
		queue_random_prune();
	endtask

	// sender: holds an offered transaction until it is taken
	always @(negedge clk) begin
		if (arst_n && (!cmd_ch.valid || cmd_taken)) begin
			if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.data <= pending_cmds[0];
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
		cmd_taken = 1'b0;
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n)
			res_ch.ready <= !hold_res && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	// accepted commands feed the model, accepted results are checked
	always @(posedge clk) begin
		ptdp_pkg::out_item_t want;
		ptdp_pkg::out_item_t got;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = apply_to_table(cmd_ch.data);
				awaited_outcomes.push_back(want);
				void'(pending_cmds.pop_front());
				cmd_taken = 1'b1;
				n_accepted++;
				calm = (n_accepted >= 400 && n_accepted < 550);
				if (cmd_ch.data.op == ptdp_pkg::OP_ADD) begin
					n_adds++;
					n_dups += want.duplicate;
					n_refused += !want.duplicate && !want.stored;
				end else begin
					n_prunes++;
					n_removed += want.removed_count;
				end
			end
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (awaited_outcomes.size() == 0) begin
					$error("result with nothing outstanding: %p", got);
					n_errors++;
				end else begin
					want = awaited_outcomes.pop_front();
					n_checked++;
					if (got.duplicate !== want.duplicate) begin
						$error("duplicate: expected %0d, got %0d", want.duplicate, got.duplicate);
						n_errors++;
					end
					if (got.stored !== want.stored) begin
						$error("stored: expected %0d, got %0d", want.stored, got.stored);
						n_errors++;
					end
					if (got.removed_count !== want.removed_count) begin
						$error("removed_count: expected %0d, got %0d",
							want.removed_count, got.removed_count);
						n_errors++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						n_errors++;
					end
				end
			end
		end
	end

	// long receiver stall so the unit backs up into the cmd channel
	initial begin
		hold_res = 1'b0;
		wait (n_accepted >= 700);
		@(negedge clk);
		hold_res = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_res = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("point_table_dedup_prune_unit: mismatch");
		$finish;
	end

	initial begin
		int mode;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		kept_count = 0;
		calm = 1'b0;

		// directed: empty table, extremes, duplicates, inclusive edges, inverted rectangles
		queue_prune(C_MIN, C_MIN, C_MAX, C_MAX);
		queue_add(C_MIN, C_MIN);
		queue_add(C_MAX, C_MAX);
		queue_add(C_MIN, C_MAX);
		queue_add(C_MAX, C_MIN);
		queue_add(C_MIN, C_MIN);
		queue_add(ptdp_pkg::coord_t'(0), ptdp_pkg::coord_t'(0));
		queue_add(ptdp_pkg::coord_t'(-1), ptdp_pkg::coord_t'(-1));
		queue_prune(C_MIN, C_MIN, C_MAX, C_MAX);
		queue_prune(ptdp_pkg::coord_t'(-1), ptdp_pkg::coord_t'(-1),
			ptdp_pkg::coord_t'(0), ptdp_pkg::coord_t'(0));
		queue_add(ptdp_pkg::coord_t'(-1), ptdp_pkg::coord_t'(-1));
		queue_add(ptdp_pkg::coord_t'(1), ptdp_pkg::coord_t'(0));
		queue_prune(ptdp_pkg::coord_t'(1), C_MIN, ptdp_pkg::coord_t'(0), C_MAX);
		queue_add(ptdp_pkg::coord_t'(5), ptdp_pkg::coord_t'(5));
		queue_prune(C_MIN, ptdp_pkg::coord_t'(1), C_MAX, ptdp_pkg::coord_t'(0));
		queue_add(C_MAX, C_MAX);
		queue_prune(C_MAX, C_MAX, C_MAX, C_MAX);
		queue_add(C_MAX, C_MAX);

		// random runs; the first one overfills the table
		repeat (66) queue_add(ptdp_pkg::coord_t'($urandom), ptdp_pkg::coord_t'($urandom));
		queue_add(C_MAX, C_MAX);
		queue_random_prune();
		while (items_queued < ITEM_TARGET) begin
			mode = $urandom_range(9);
			if (mode < 6) begin
				repeat ($urandom_range(40, 10)) begin
					if ($urandom_range(7) == 0)
						queue_random_prune();
					else
						queue_add(grid_coord(), grid_coord());
				end
			end else if (mode < 9) begin
				queue_fill_run();
			end else begin
				repeat ($urandom_range(8, 2)) begin
					if ($urandom_range(1))
						queue_prune(any_coord(), any_coord(), any_coord(), any_coord());
					else
						queue_add(any_coord(), any_coord());
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_outcomes.size() != 0) begin
			$error("%0d results never arrived", awaited_outcomes.size());
			n_errors++;
		end

		$display("ran %0d transactions, %0d results checked, %0d errors",
			n_accepted, n_checked, n_errors);
		$display("adds %0d (duplicates %0d, dropped on full table %0d), prunes %0d removing %0d",
			n_adds, n_dups, n_refused, n_prunes, n_removed);
		if (n_errors == 0)
			$display("point_table_dedup_prune_unit: match");
		else
			$display("point_table_dedup_prune_unit: mismatch");
		$finish;
	end
endmodule
